[rtl/json_syntax_validator_assert.svh]
// Assertion macros used by the checker file.
`ifndef JSON_SYNTAX_VALIDATOR_ASSERT_SVH
`define JSON_SYNTAX_VALIDATOR_ASSERT_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define JSV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Asserts that an antecedent implies a consequent in the next cycle.
`define JSV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/jsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON validator package
// Types, constants and grammar states shared by the validator files.
// ----------------------------------------------------------------------------
package jsv_pkg;

   localparam int MaxNesting = 128;
   localparam int LevelWidth = $clog2(MaxNesting + 2);
   localparam int CountWidth = 18;
   localparam logic [CountWidth-1:0] MaxValuesReset = 18'd200000;

   typedef enum logic [1:0] {
      VERDICT_PENDING  = 2'd0,
      VERDICT_ACCEPTED = 2'd1,
      VERDICT_REJECTED = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SYNTAX  = 2'd1,
      ERR_NESTING = 2'd2,
      ERR_VALUES  = 2'd3
   } error_type;

   typedef enum logic [4:0] {
      GS_VALUE, GS_ARR_FIRST, GS_OBJ_FIRST, GS_KEY, GS_COLON, GS_AFTER, GS_DONE,
      GS_LIT_T, GS_LIT_F, GS_LIT_N,
      GS_NUM_MINUS, GS_NUM_ZERO, GS_NUM_INT, GS_NUM_DOT, GS_NUM_FRAC,
      GS_NUM_E, GS_NUM_ESIGN, GS_NUM_EXP,
      GS_VSTR, GS_VESC, GS_VHEX, GS_VSBS, GS_VSU,
      GS_KSTR, GS_KESC, GS_KHEX, GS_KSBS, GS_KSU
   } grammar_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [1:0] error_kind;
      logic       document_end;
   } rsp_type;

endpackage

[rtl/jsv_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON validator stream interface
// Valid/ready channels carrying one request, result or value-limit payload.
// ----------------------------------------------------------------------------
interface jsv_req_if;
   logic              valid;
   logic              ready;
   jsv_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface jsv_rsp_if;
   logic              valid;
   logic              ready;
   jsv_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface jsv_csr_if;
   logic                              valid;
   logic                              ready;
   logic [jsv_pkg::CountWidth-1:0]    data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/json_syntax_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON syntax validator
// Streaming checker of one JSON document, one byte per request.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless the result side stalls, and returns each
// result in the next cycle; the whole grammar step is a single pass of logic
// between the request register state and the result register. The container
// marks live in a 129-entry memory indexed by the nesting level. The top two
// marks are kept in registers, and the memory is read, into a register, only
// when a container closes. Throughput is one request per cycle while the
// result side takes results.
module json_syntax_validator (
   input  logic        clock,
   input  logic        reset,
   jsv_req_if.sink     req,
   jsv_rsp_if.source   rsp,
   jsv_csr_if.sink     csr
);

   localparam int StackDepth = jsv_pkg::MaxNesting + 1;

   logic [jsv_pkg::CountWidth-1:0] max_values_ff;
   jsv_pkg::grammar_type           gs_ff, gs_in;
   logic [jsv_pkg::LevelWidth-1:0] level_ff, level_in;
   logic [jsv_pkg::CountWidth-1:0] count_ff, count_in;
   logic [2:0]                     hex_cnt_ff, hex_cnt_in;
   logic [15:0]                    hex_acc_ff, hex_acc_in;
   logic                           hi_pend_ff, hi_pend_in;
   logic [2:0]                     lit_ff, lit_in;
   logic [1:0]                     err_ff, err_in;
   logic                           stack_mem [0:StackDepth-1];
   logic                           top_ff, below_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   jsv_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   jsv_pkg::grammar_type s_gs;
   logic [jsv_pkg::LevelWidth-1:0] s_level;
   logic [jsv_pkg::CountWidth-1:0] s_count;
   logic [2:0]  s_hex_cnt, s_lit;
   logic [15:0] s_hex_acc;
   logic        s_hi, push, push_obj, pop, top_obj, accept, ok, doc_end, commit;
   jsv_pkg::error_type s_err;
   logic [1:0]  err_next;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

   assign top_obj = top_ff;
   assign commit = accept && err_ff == jsv_pkg::ERR_NONE && s_err == jsv_pkg::ERR_NONE &&
                   !doc_end;

   jsv_step u_step (
      .gs(gs_ff), .level(level_ff), .count(count_ff), .max_values(max_values_ff),
      .hex_cnt(hex_cnt_ff), .hex_acc(hex_acc_ff), .hi_pend(hi_pend_ff),
      .lit_prog(lit_ff), .top_is_obj(top_obj), .c(req.data.byte_in),
      .gs_out(s_gs), .level_out(s_level), .count_out(s_count),
      .hex_cnt_out(s_hex_cnt), .hex_acc_out(s_hex_acc), .hi_pend_out(s_hi),
      .lit_prog_out(s_lit), .push(push), .push_obj(push_obj), .pop(pop), .err(s_err)
   );

   always_comb begin
      doc_end = req.data.last;
      err_next = err_ff;
      if (err_ff == jsv_pkg::ERR_NONE) err_next = s_err;
      ok = (s_gs == jsv_pkg::GS_DONE) ||
           (s_level == '0 && (s_gs == jsv_pkg::GS_NUM_ZERO || s_gs == jsv_pkg::GS_NUM_INT ||
                              s_gs == jsv_pkg::GS_NUM_FRAC || s_gs == jsv_pkg::GS_NUM_EXP));
      if (doc_end && err_next == jsv_pkg::ERR_NONE && !ok) err_next = jsv_pkg::ERR_SYNTAX;
      rsp_data_in.error_kind = err_next;
      rsp_data_in.document_end = doc_end;
      if (err_next != jsv_pkg::ERR_NONE) rsp_data_in.verdict = jsv_pkg::VERDICT_REJECTED;
      else if (doc_end) rsp_data_in.verdict = jsv_pkg::VERDICT_ACCEPTED;
      else rsp_data_in.verdict = jsv_pkg::VERDICT_PENDING;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

      gs_in = gs_ff; level_in = level_ff; count_in = count_ff;
      hex_cnt_in = hex_cnt_ff; hex_acc_in = hex_acc_ff; hi_pend_in = hi_pend_ff;
      lit_in = lit_ff; err_in = err_ff;
      if (accept) begin
         if (doc_end) begin
            gs_in = jsv_pkg::GS_VALUE; level_in = '0; count_in = '0;
            hex_cnt_in = '0; hex_acc_in = '0; hi_pend_in = 1'b0; lit_in = '0;
            err_in = jsv_pkg::ERR_NONE;
         end else if (err_ff == jsv_pkg::ERR_NONE) begin
            err_in = s_err;
            if (s_err == jsv_pkg::ERR_NONE) begin
               gs_in = s_gs; level_in = s_level; count_in = s_count;
               hex_cnt_in = s_hex_cnt; hex_acc_in = s_hex_acc; hi_pend_in = s_hi;
               lit_in = s_lit;
            end else begin
               hex_acc_in = s_hex_acc; hex_cnt_in = s_hex_cnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_values_ff <= jsv_pkg::MaxValuesReset;
         gs_ff <= jsv_pkg::GS_VALUE;
         level_ff <= '0;
         count_ff <= '0;
         hex_cnt_ff <= '0;
         hex_acc_ff <= '0;
         hi_pend_ff <= 1'b0;
         lit_ff <= '0;
         err_ff <= jsv_pkg::ERR_NONE;
         top_ff <= 1'b0;
         below_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) max_values_ff <= csr.data;
         gs_ff <= gs_in;
         level_ff <= level_in;
         count_ff <= count_in;
         hex_cnt_ff <= hex_cnt_in;
         hex_acc_ff <= hex_acc_in;
         hi_pend_ff <= hi_pend_in;
         lit_ff <= lit_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         // On a close the mark below the new top comes from the memory; it
         // sits three places under the current level.
         if (accept && doc_end) begin
            top_ff <= 1'b0;
            below_ff <= 1'b0;
         end else if (commit && push) begin
            top_ff <= push_obj;
            below_ff <= top_ff;
         end else if (commit && pop) begin
            top_ff <= below_ff;
            if (level_ff >= jsv_pkg::LevelWidth'(3))
               below_ff <= stack_mem[level_ff - jsv_pkg::LevelWidth'(3)];
            else
               below_ff <= 1'b0;
         end
      end
   end

   // Entries above the level are stale but are always rewritten before use.
   always_ff @(posedge clock) begin
      if (commit && push && level_ff < jsv_pkg::LevelWidth'(StackDepth))
         stack_mem[level_ff] <= push_obj;
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/jsv_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON validator grammar step
// Combinational next-state logic for one document byte.
// ----------------------------------------------------------------------------
module jsv_step (
   input  jsv_pkg::grammar_type               gs,
   input  logic [jsv_pkg::LevelWidth-1:0]     level,
   input  logic [jsv_pkg::CountWidth-1:0]     count,
   input  logic [jsv_pkg::CountWidth-1:0]     max_values,
   input  logic [2:0]                         hex_cnt,
   input  logic [15:0]                        hex_acc,
   input  logic                               hi_pend,
   input  logic [2:0]                         lit_prog,
   input  logic                               top_is_obj,
   input  logic [7:0]                         c,
   output jsv_pkg::grammar_type               gs_out,
   output logic [jsv_pkg::LevelWidth-1:0]     level_out,
   output logic [jsv_pkg::CountWidth-1:0]     count_out,
   output logic [2:0]                         hex_cnt_out,
   output logic [15:0]                        hex_acc_out,
   output logic                               hi_pend_out,
   output logic [2:0]                         lit_prog_out,
   output logic                               push,
   output logic                               push_obj,
   output logic                               pop,
   output jsv_pkg::error_type                 err
);

   logic       is_dig, is_e, is_sp, hex_ok, num_st, consumed, is_key;
   logic [3:0] hex_val;
   logic [15:0] acc_n;
   logic [7:0]  lit_ch;
   logic [2:0]  lit_len;
   jsv_pkg::grammar_type base, g2;

   always_comb begin
      is_dig = (c >= 8'h30) && (c <= 8'h39);
      is_e   = (c == "e") || (c == "E");
      is_sp  = (c == " ") || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
      hex_ok = 1'b1;
      hex_val = 4'd0;
      if (is_dig) hex_val = c[3:0];
      else if (c >= "a" && c <= "f") hex_val = 4'(c - 8'h57);
      else if (c >= "A" && c <= "F") hex_val = 4'(c - 8'h37);
      else hex_ok = 1'b0;
      acc_n = {hex_acc[11:0], hex_val};
      unique case (gs)
         jsv_pkg::GS_LIT_T: begin
            lit_len = 3'd4;
            unique case (lit_prog)
               3'd0: lit_ch = "t";
               3'd1: lit_ch = "r";
               3'd2: lit_ch = "u";
               3'd3: lit_ch = "e";
               default: lit_ch = 8'h00;
            endcase
         end
         jsv_pkg::GS_LIT_F: begin
            lit_len = 3'd5;
            unique case (lit_prog)
               3'd0: lit_ch = "f";
               3'd1: lit_ch = "a";
               3'd2: lit_ch = "l";
               3'd3: lit_ch = "s";
               3'd4: lit_ch = "e";
               default: lit_ch = 8'h00;
            endcase
         end
         default: begin
            lit_len = 3'd4;
            unique case (lit_prog)
               3'd0: lit_ch = "n";
               3'd1: lit_ch = "u";
               3'd2: lit_ch = "l";
               3'd3: lit_ch = "l";
               default: lit_ch = 8'h00;
            endcase
         end
      endcase
   end

   always_comb begin
      gs_out = gs;
      level_out = level;
      count_out = count;
      hex_cnt_out = hex_cnt;
      hex_acc_out = hex_acc;
      hi_pend_out = hi_pend;
      lit_prog_out = lit_prog;
      push = 1'b0;
      push_obj = 1'b0;
      pop = 1'b0;
      err = jsv_pkg::ERR_NONE;
      consumed = 1'b0;
      is_key = 1'b0;
      base = jsv_pkg::GS_VSTR;
      g2 = gs;
      num_st = (gs >= jsv_pkg::GS_NUM_MINUS) && (gs <= jsv_pkg::GS_NUM_EXP);
      // Number states: a byte that does not extend a complete number ends it and
      // is handled as the byte after the value; after -, . or e it is an error.
      if (num_st) begin
         consumed = 1'b1;
         unique case (gs)
            jsv_pkg::GS_NUM_MINUS: begin
               if (c == "0") gs_out = jsv_pkg::GS_NUM_ZERO;
               else if (is_dig) gs_out = jsv_pkg::GS_NUM_INT;
               else err = jsv_pkg::ERR_SYNTAX;
            end
            jsv_pkg::GS_NUM_ZERO, jsv_pkg::GS_NUM_INT: begin
               if (is_dig && gs == jsv_pkg::GS_NUM_INT) gs_out = gs;
               else if (c == ".") gs_out = jsv_pkg::GS_NUM_DOT;
               else if (is_e) gs_out = jsv_pkg::GS_NUM_E;
               else consumed = 1'b0;
            end
            jsv_pkg::GS_NUM_DOT: begin
               if (is_dig) gs_out = jsv_pkg::GS_NUM_FRAC;
               else err = jsv_pkg::ERR_SYNTAX;
            end
            jsv_pkg::GS_NUM_FRAC: begin
               if (is_e) gs_out = jsv_pkg::GS_NUM_E;
               else if (!is_dig) consumed = 1'b0;
            end
            jsv_pkg::GS_NUM_E: begin
               if (c == "+" || c == "-") gs_out = jsv_pkg::GS_NUM_ESIGN;
               else if (is_dig) gs_out = jsv_pkg::GS_NUM_EXP;
               else err = jsv_pkg::ERR_SYNTAX;
            end
            jsv_pkg::GS_NUM_ESIGN: begin
               if (is_dig) gs_out = jsv_pkg::GS_NUM_EXP;
               else err = jsv_pkg::ERR_SYNTAX;
            end
            default: begin
               if (!is_dig) consumed = 1'b0;
            end
         endcase
         if (!consumed) g2 = (level == '0) ? jsv_pkg::GS_DONE : jsv_pkg::GS_AFTER;
         gs_out = consumed ? gs_out : g2;
      end
      if (!consumed) begin
         is_key = (g2 >= jsv_pkg::GS_KSTR);
         base = is_key ? jsv_pkg::GS_KSTR : jsv_pkg::GS_VSTR;
         if (g2 >= jsv_pkg::GS_VSTR) begin
            unique case (3'(g2 - base))
               3'd0: begin
                  if (c == "\"") begin
                     if (is_key) gs_out = jsv_pkg::GS_COLON;
                     else gs_out = (level == '0) ? jsv_pkg::GS_DONE : jsv_pkg::GS_AFTER;
                  end else if (c < 8'h20) err = jsv_pkg::ERR_SYNTAX;
                  else if (c == "\\") gs_out = jsv_pkg::grammar_type'(base + 5'd1);
               end
               3'd1: begin
                  if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                      c == "n" || c == "r" || c == "t") gs_out = base;
                  else if (c == "u") begin
                     gs_out = jsv_pkg::grammar_type'(base + 5'd2);
                     hex_cnt_out = 3'd0;
                     hex_acc_out = 16'd0;
                  end else err = jsv_pkg::ERR_SYNTAX;
               end
               3'd2: begin
                  if (!hex_ok) err = jsv_pkg::ERR_SYNTAX;
                  else begin
                     hex_acc_out = acc_n;
                     hex_cnt_out = hex_cnt + 3'd1;
                     if (hex_cnt == 3'd3) begin
                        hex_cnt_out = 3'd0;
                        if (hi_pend) begin
                           if (acc_n >= 16'hdc00 && acc_n <= 16'hdfff) begin
                              hi_pend_out = 1'b0;
                              gs_out = base;
                           end else err = jsv_pkg::ERR_SYNTAX;
                        end else if (acc_n >= 16'hd800 && acc_n <= 16'hdbff) begin
                           hi_pend_out = 1'b1;
                           gs_out = jsv_pkg::grammar_type'(base + 5'd3);
                        end else if (acc_n >= 16'hdc00 && acc_n <= 16'hdfff) begin
                           err = jsv_pkg::ERR_SYNTAX;
                        end else gs_out = base;
                     end
                  end
               end
               3'd3: begin
                  if (c == "\\") gs_out = jsv_pkg::grammar_type'(base + 5'd4);
                  else err = jsv_pkg::ERR_SYNTAX;
               end
               default: begin
                  if (c == "u") begin
                     gs_out = jsv_pkg::grammar_type'(base + 5'd2);
                     hex_cnt_out = 3'd0;
                     hex_acc_out = 16'd0;
                  end else err = jsv_pkg::ERR_SYNTAX;
               end
            endcase
         end else if (g2 == jsv_pkg::GS_LIT_T || g2 == jsv_pkg::GS_LIT_F ||
                      g2 == jsv_pkg::GS_LIT_N) begin
            if (lit_prog >= lit_len || c != lit_ch) err = jsv_pkg::ERR_SYNTAX;
            else if (lit_prog + 3'd1 == lit_len) begin
               lit_prog_out = 3'd0;
               gs_out = (level == '0) ? jsv_pkg::GS_DONE : jsv_pkg::GS_AFTER;
            end else lit_prog_out = lit_prog + 3'd1;
         end else if (!is_sp) begin
            priority if (g2 == jsv_pkg::GS_VALUE ||
                         (g2 == jsv_pkg::GS_ARR_FIRST && c != "]")) begin
               if (level > jsv_pkg::LevelWidth'(jsv_pkg::MaxNesting))
                  err = jsv_pkg::ERR_NESTING;
               else if (count >= max_values) err = jsv_pkg::ERR_VALUES;
               else begin
                  count_out = count + 1'b1;
                  lit_prog_out = 3'd1;
                  if (c == "\"") gs_out = jsv_pkg::GS_VSTR;
                  else if (c == "{" || c == "[") begin
                     push = 1'b1;
                     push_obj = (c == "{");
                     level_out = level + 1'b1;
                     gs_out = (c == "{") ? jsv_pkg::GS_OBJ_FIRST : jsv_pkg::GS_ARR_FIRST;
                  end
                  else if (c == "t") gs_out = jsv_pkg::GS_LIT_T;
                  else if (c == "f") gs_out = jsv_pkg::GS_LIT_F;
                  else if (c == "n") gs_out = jsv_pkg::GS_LIT_N;
                  else if (c == "-") gs_out = jsv_pkg::GS_NUM_MINUS;
                  else if (c == "0") gs_out = jsv_pkg::GS_NUM_ZERO;
                  else if (is_dig) gs_out = jsv_pkg::GS_NUM_INT;
                  else err = jsv_pkg::ERR_SYNTAX;
               end
            end else if (g2 == jsv_pkg::GS_ARR_FIRST ||
                         (g2 == jsv_pkg::GS_OBJ_FIRST && c == "}") ||
                         (g2 == jsv_pkg::GS_AFTER && level != '0 &&
                          ((c == "]" && !top_is_obj) || (c == "}" && top_is_obj)))) begin
               pop = 1'b1;
               level_out = level - 1'b1;
               gs_out = (level == jsv_pkg::LevelWidth'(1)) ? jsv_pkg::GS_DONE
                                                           : jsv_pkg::GS_AFTER;
            end else if ((g2 == jsv_pkg::GS_OBJ_FIRST || g2 == jsv_pkg::GS_KEY) &&
                         c == "\"") begin
               gs_out = jsv_pkg::GS_KSTR;
            end else if (g2 == jsv_pkg::GS_COLON && c == ":") begin
               gs_out = jsv_pkg::GS_VALUE;
            end else if (g2 == jsv_pkg::GS_AFTER && level != '0 && c == ",") begin
               gs_out = top_is_obj ? jsv_pkg::GS_KEY : jsv_pkg::GS_VALUE;
            end else begin
               err = jsv_pkg::ERR_SYNTAX;
            end
         end
      end
   end

endmodule

[rtl/jsv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON validator port checker
// Watches the top-level ports for handshake and verdict consistency.
// ----------------------------------------------------------------------------
`include "json_syntax_validator_assert.svh"

module jsv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input jsv_pkg::rsp_type rsp_data
);

   `JSV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `JSV_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid && rsp_data.document_end == $past(req_last), "request without result")
   `JSV_ASSERT_IMP(a_accept_clean, clock, reset, rsp_valid && rsp_data.verdict == jsv_pkg::VERDICT_ACCEPTED, rsp_data.error_kind == jsv_pkg::ERR_NONE && rsp_data.document_end, "accepted with error")
   `JSV_ASSERT_IMP(a_reject_kind, clock, reset, rsp_valid && rsp_data.error_kind != jsv_pkg::ERR_NONE, rsp_data.verdict == jsv_pkg::VERDICT_REJECTED, "error without rejection")

endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_last(req.data.last),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
